FILE: sv/wgp_pkg.sv
// Shared types and constants for the window gap planner.
package wgp_pkg;

	localparam int MAX_GAPS = 64;
	localparam int CNT_W    = $clog2(MAX_GAPS + 1);
	localparam int ADDR_W   = 64;
	localparam int RES_MAX  = 3;

	localparam logic OP_REGION = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [1:0] ST_FREE      = 2'd0;
	localparam logic [1:0] ST_RESERVED  = 2'd1;
	localparam logic [1:0] ST_COMMITTED = 2'd2;

	localparam logic [1:0] REG_WIN_BASE  = 2'd0;
	localparam logic [1:0] REG_WIN_SIZE  = 2'd1;
	localparam logic [1:0] REG_GAP_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		KIND_GAP  = 2'd0,
		KIND_DONE = 2'd1,
		KIND_FAIL = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  base;
		logic [ADDR_W-1:0]  size;
		logic [CNT_W-1:0]   count;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [1:0]              num;
		result_t [RES_MAX-1:0]   item;
	} push_t;

endpackage

FILE: sv/wgp_plan.sv
// Gap planning datapath: cursor, pending gap and per-item result list.
module wgp_plan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic                       op,
	input  logic [wgp_pkg::ADDR_W-1:0] rb,
	input  logic [wgp_pkg::ADDR_W-1:0] re,
	input  logic [1:0]                 st,
	input  logic [wgp_pkg::ADDR_W-1:0] window_base,
	input  logic [wgp_pkg::ADDR_W-1:0] window_end,
	input  logic                       window_ok,
	input  logic [wgp_pkg::CNT_W-1:0]  limit,
	input  logic                       cfg_restart,
	input  logic [wgp_pkg::ADDR_W-1:0] cfg_base,
	output wgp_pkg::push_t             push
);
	import wgp_pkg::*;

	logic [ADDR_W-1:0] cursor_q, pend_base_q, pend_size_q, pend_end_q;
	logic              pend_valid_q, failed_q;
	logic [CNT_W-1:0]  opened_q;

	logic [ADDR_W-1:0] cursor_n, pend_base_n, pend_size_n, pend_end_n;
	logic              pend_valid_n, failed_n;
	logic [CNT_W-1:0]  opened_n;

	logic              fail0, cur_lt_end, skip, hole, is_free;
	logic [ADDR_W-1:0] chi, gap_end, gs;
	logic              do_offer, merge, lim_hit, fail_offer, emit_old;
	logic              finish_fail;

	assign fail0      = failed_q | ~window_ok;
	assign cur_lt_end = cursor_q < window_end;
	assign hole       = rb > cursor_q;
	assign is_free    = st == ST_FREE;
	assign chi        = (re < window_end) ? re : window_end;
	assign skip       = fail0 | ~cur_lt_end | (re <= cursor_q) | (rb >= window_end);

	// A hole and the free region after it always merge, so offer them as one gap.
	always_comb begin
		if (op == OP_REGION) begin
			do_offer = ~skip & (hole | is_free);
			gap_end  = is_free ? chi : rb;
		end else begin
			do_offer = ~fail0 & cur_lt_end;
			gap_end  = window_end;
		end
	end

	assign gs          = gap_end - cursor_q;
	assign merge       = pend_valid_q & (pend_end_q == cursor_q);
	assign lim_hit     = opened_q >= limit;
	assign fail_offer  = do_offer & ~merge & lim_hit;
	assign emit_old    = do_offer & ~merge & ~lim_hit & pend_valid_q;
	assign finish_fail = fail0 | fail_offer;

	always_comb begin
		pend_base_n  = pend_base_q;
		pend_size_n  = pend_size_q;
		pend_end_n   = pend_end_q;
		pend_valid_n = pend_valid_q;
		opened_n     = opened_q;
		if (do_offer && merge) begin
			pend_size_n = pend_size_q + gs;
			pend_end_n  = gap_end;
		end else if (do_offer && !lim_hit) begin
			pend_base_n  = cursor_q;
			pend_size_n  = gs;
			pend_end_n   = gap_end;
			pend_valid_n = 1'b1;
			opened_n     = opened_q + 1'b1;
		end
		cursor_n = cursor_q;
		failed_n = fail0;
		if (op == OP_REGION && !skip) begin
			failed_n = fail0 | fail_offer | (st == ST_COMMITTED);
			cursor_n = chi;
		end
	end

	// Build the result list in delivery order.
	always_comb begin
		logic [1:0] idx;
		idx  = 2'd0;
		push = '0;
		if (go) begin
			if (emit_old && !(op == OP_FINISH && finish_fail)) begin
				push.item[idx].kind = KIND_GAP;
				push.item[idx].base = pend_base_q;
				push.item[idx].size = pend_size_q;
				idx = idx + 2'd1;
			end
			if (op == OP_FINISH) begin
				if (finish_fail) begin
					push.item[idx].kind = KIND_FAIL;
					push.item[idx].last = 1'b1;
					idx = idx + 2'd1;
				end else begin
					if (pend_valid_n) begin
						push.item[idx].kind = KIND_GAP;
						push.item[idx].base = pend_base_n;
						push.item[idx].size = pend_size_n;
						idx = idx + 2'd1;
					end
					push.item[idx].kind  = KIND_DONE;
					push.item[idx].count = opened_n;
					push.item[idx].last  = 1'b1;
					idx = idx + 2'd1;
				end
			end
			push.num = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			pend_base_q  <= '0;
			pend_size_q  <= '0;
			pend_end_q   <= '0;
			pend_valid_q <= 1'b0;
			opened_q     <= '0;
			failed_q     <= 1'b0;
		end else if (cfg_restart || (go && op == OP_FINISH)) begin
			cursor_q     <= cfg_restart ? cfg_base : window_base;
			pend_base_q  <= '0;
			pend_size_q  <= '0;
			pend_end_q   <= '0;
			pend_valid_q <= 1'b0;
			opened_q     <= '0;
			failed_q     <= 1'b0;
		end else if (go) begin
			cursor_q     <= cursor_n;
			pend_base_q  <= pend_base_n;
			pend_size_q  <= pend_size_n;
			pend_end_q   <= pend_end_n;
			pend_valid_q <= pend_valid_n;
			opened_q     <= opened_n;
			failed_q     <= failed_n;
		end
	end

	a_finish_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		go && op == OP_FINISH |=> !pend_valid_q && !failed_q && opened_q == '0)
		else $error("plan state not cleared after finish");

	a_region_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		go && op == OP_REGION |-> push.num <= 2'd1)
		else $error("region item produced more than one result");

	a_finish_reports: assert property (@(posedge clk) disable iff (!arst_n)
		go && op == OP_FINISH |-> push.num != 2'd0)
		else $error("finish item produced no status");

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		opened_q <= CNT_W'(MAX_GAPS))
		else $error("gap count beyond maximum");

endmodule

FILE: sv/wgp_rfifo.sv
// Result queue: takes up to three results per cycle, delivers one per transfer.
module wgp_rfifo (
	input  logic                clk,
	input  logic                arst_n,
	input  wgp_pkg::push_t      push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output wgp_pkg::result_t    head
);
	import wgp_pkg::*;

	localparam int DEPTH = RES_MAX + 1;
	localparam int PTR_W = $clog2(DEPTH);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [PTR_W:0]     count_q;
	logic               pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = count_q != '0;
	assign head      = mem_q[head_q];
	// Leave space for the largest burst one item can cause.
	assign room      = count_q <= (PTR_W+1)'(DEPTH - RES_MAX);

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (2'(i) < push.num) begin
				mem_q[tail_q + PTR_W'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PTR_W'(push.num);
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push.num) - (PTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> count_q - (PTR_W+1)'(pop) + (PTR_W+1)'(push.num)
			<= (PTR_W+1)'(DEPTH))
		else $error("result queue overflow");

endmodule

FILE: sv/window_gap_planner.sv
// Top level: APB registers, input stage, planner and result queue.
// The first result of an item goes through the input register and then the result queue
// before it is valid at the output.
// Throughput: one region item per cycle while the queue has room; a finish item gives up
// to three results, draining one per cycle (while out_ready) through the four-entry queue.
// Input stalls while an item waits in the input register and the queue holds more than one.
// Reset: window_base 0, window_size 0, gap_limit 64, empty plan and queue; no clearing pass.
module window_gap_planner (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [4:0]                 paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic [wgp_pkg::ADDR_W-1:0] region_base,
	input  logic [wgp_pkg::ADDR_W-1:0] region_size,
	input  logic [1:0]                 region_state,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 kind,
	output logic [wgp_pkg::ADDR_W-1:0] gap_base,
	output logic [wgp_pkg::ADDR_W-1:0] gap_size,
	output logic [wgp_pkg::CNT_W-1:0]  gap_count,
	output logic                       last
);
	import wgp_pkg::*;

	logic [ADDR_W-1:0] win_base_q, win_size_q, win_end_q;
	logic [6:0]        gap_limit_q;
	logic [CNT_W-1:0]  limit_q;
	logic              win_ok_q;
	logic [1:0]        reg_idx;
	logic              wr_en, cfg_restart;
	logic [ADDR_W-1:0] cfg_base;

	logic              valid_s1, op_s1;
	logic [1:0]        st_s1;
	logic [ADDR_W-1:0] rb_s1, re_s1;
	logic              room, go;

	push_t             push;
	result_t           head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg_restart = wr_en & (reg_idx == REG_WIN_BASE || reg_idx == REG_WIN_SIZE ||
		reg_idx == REG_GAP_LIMIT);
	assign cfg_base = (reg_idx == REG_WIN_BASE) ? pwdata : win_base_q;

	always_comb begin
		case (reg_idx)
			REG_WIN_BASE:  prdata = win_base_q;
			REG_WIN_SIZE:  prdata = win_size_q;
			REG_GAP_LIMIT: prdata = {57'd0, gap_limit_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_base_q  <= '0;
			win_size_q  <= '0;
			gap_limit_q <= 7'(MAX_GAPS);
		end else if (wr_en) begin
			case (reg_idx)
				REG_WIN_BASE:  win_base_q  <= pwdata;
				REG_WIN_SIZE:  win_size_q  <= pwdata;
				REG_GAP_LIMIT: gap_limit_q <= pwdata[6:0];
				default:       ;
			endcase
		end
	end

	// Window end, validity and clamped limit are registered and follow the registers in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_end_q <= '0;
			win_ok_q  <= 1'b0;
			limit_q   <= CNT_W'(MAX_GAPS);
		end else begin
			win_end_q <= win_base_q + win_size_q;
			win_ok_q  <= (win_base_q + win_size_q > win_base_q) && gap_limit_q != '0;
			limit_q   <= (gap_limit_q > 7'(MAX_GAPS)) ? CNT_W'(MAX_GAPS) : CNT_W'(gap_limit_q);
		end
	end

	assign go       = valid_s1 & room;
	assign in_ready = ~valid_s1 | room;

	// Input register; region end is summed here to split the add from the compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			st_s1 <= region_state;
			rb_s1 <= region_base;
			re_s1 <= region_base + region_size;
		end
	end

	wgp_plan u_plan (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.op          (op_s1),
		.rb          (rb_s1),
		.re          (re_s1),
		.st          (st_s1),
		.window_base (win_base_q),
		.window_end  (win_end_q),
		.window_ok   (win_ok_q),
		.limit       (limit_q),
		.cfg_restart (cfg_restart),
		.cfg_base    (cfg_base),
		.push        (push)
	);

	wgp_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind      = head.kind;
	assign gap_base  = head.base;
	assign gap_size  = head.size;
	assign gap_count = head.count;
	assign last      = head.last;

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && !room)
		else $error("input stalled without a held item");

endmodule

FILE: verif/gap_plan_checker.sv
// Checker for the window gap planner: tracks both channels, predicts results and compares them.
module gap_plan_checker
	import wgp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [4:0]           paddr,
	input  logic [63:0]          pwdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 op,
	input  logic [ADDR_W-1:0]    region_base,
	input  logic [ADDR_W-1:0]    region_size,
	input  logic [1:0]           region_state,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [1:0]           kind,
	input  logic [ADDR_W-1:0]    gap_base,
	input  logic [ADDR_W-1:0]    gap_size,
	input  logic [CNT_W-1:0]     gap_count,
	input  logic                 last,
	output int                   errors,
	output int                   waiting
);

	logic [63:0] win_base;
	logic [63:0] win_size;
	logic [6:0]  lim_reg;

	logic [63:0] cur;
	logic [63:0] pend_base;
	logic [63:0] pend_size;
	logic        pend_valid;
	logic [6:0]  opened;
	logic        failed;

	result_t expected_q[$];

	task automatic restart_plan();
		cur        = win_base;
		pend_base  = '0;
		pend_size  = '0;
		pend_valid = 1'b0;
		opened     = '0;
		failed     = 1'b0;
	endtask

	function automatic logic [6:0] gap_cap();
		return (lim_reg > MAX_GAPS) ? 7'(MAX_GAPS) : lim_reg;
	endfunction

	task automatic post(input kind_t k, input logic [63:0] b, input logic [63:0] s,
			input logic [6:0] c, input logic l);
		result_t r;
		r.kind  = k;
		r.base  = b;
		r.size  = s;
		r.count = c;
		r.last  = l;
		expected_q.push_back(r);
	endtask

	// Merge into the pending gap when it abuts, else fail at the gap limit or send the pending one and open a new one.
	task automatic offer_gap(input logic [63:0] b, input logic [63:0] s);
		if (s == 0)
			return;
		if (pend_valid && pend_base + pend_size == b) begin
			pend_size = pend_size + s;
			return;
		end
		if (opened >= gap_cap()) begin
			failed = 1'b1;
			return;
		end
		if (pend_valid)
			post(KIND_GAP, pend_base, pend_size, '0, 1'b0);
		pend_base  = b;
		pend_size  = s;
		pend_valid = 1'b1;
		opened     = opened + 1'b1;
	endtask

	task automatic plan_item(input logic o, input logic [63:0] rb, input logic [63:0] rs,
			input logic [1:0] st);
		logic [63:0] w_end;
		logic [63:0] r_end;
		logic [63:0] clip;
		w_end = win_base + win_size;
		if (!failed && !(w_end > win_base && lim_reg != 0))
			failed = 1'b1;
		if (o == OP_REGION) begin
			if (failed || cur >= w_end)
				return;
			r_end = rb + rs;
			if (r_end <= cur || rb >= w_end)
				return;
			if (rb > cur) begin
				offer_gap(cur, rb - cur);
				if (failed)
					return;
				cur = rb;
			end
			clip = (r_end < w_end) ? r_end : w_end;
			if (st == ST_COMMITTED) begin
				failed = 1'b1;
				return;
			end
			if (st == ST_FREE) begin
				offer_gap(cur, clip - cur);
				if (failed)
					return;
			end
			cur = clip;
			return;
		end
		// finish: flush the tail, then the pending gap and the status
		if (!failed && cur < w_end)
			offer_gap(cur, w_end - cur);
		if (failed) begin
			post(KIND_FAIL, '0, '0, '0, 1'b1);
		end else begin
			if (pend_valid)
				post(KIND_GAP, pend_base, pend_size, '0, 1'b0);
			post(KIND_DONE, '0, '0, opened, 1'b1);
		end
		restart_plan();
	endtask

	task automatic reg_write(input logic [4:0] addr, input logic [63:0] data);
		if (addr == {REG_WIN_BASE, 3'b000})
			win_base = data;
		else if (addr == {REG_WIN_SIZE, 3'b000})
			win_size = data;
		else if (addr == {REG_GAP_LIMIT, 3'b000})
			lim_reg = data[6:0];
		else
			return;
		restart_plan();
	endtask

	task automatic check_result();
		result_t want;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result: expected none, got kind %0d base %h size %h count %0d last %0d",
				$time, kind, gap_base, gap_size, gap_count, last);
			return;
		end
		want = expected_q.pop_front();
		if (kind !== want.kind || gap_base !== want.base || gap_size !== want.size ||
				gap_count !== want.count || last !== want.last) begin
			errors++;
			$display("%0t: result mismatch: expected kind %0d base %h size %h count %0d last %0d",
				$time, want.kind, want.base, want.size, want.count, want.last);
			$display("%0t:                  actual kind %0d base %h size %h count %0d last %0d",
				$time, kind, gap_base, gap_size, gap_count, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_base = '0;
			win_size = '0;
			lim_reg  = 7'd64;
			restart_plan();
			expected_q.delete();
			errors  = 0;
			waiting = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				reg_write(paddr, pwdata);
			if (in_valid && in_ready)
				plan_item(op, region_base, region_size, region_state);
			if (out_valid && out_ready)
				check_result();
			waiting = expected_q.size();
		end
	end

endmodule

FILE: verif/window_gap_planner_tb.sv
// Testbench top for the window gap planner: clock, reset, stimulus and verdict.
module window_gap_planner_tb;
	import wgp_pkg::*;

	localparam int         CYCLE_LIMIT = 200000;
	localparam logic [1:0] ST_SPARE    = 2'd3; // unused state code, planner treats it as reserved

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [63:0]        pwdata;
	logic [63:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               op;
	logic [ADDR_W-1:0]  region_base;
	logic [ADDR_W-1:0]  region_size;
	logic [1:0]         region_state;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         kind;
	logic [ADDR_W-1:0]  gap_base;
	logic [ADDR_W-1:0]  gap_size;
	logic [CNT_W-1:0]   gap_count;
	logic               last;

	int errors;
	int waiting;
	int cycles = 0;
	bit steady = 1'b0;
	bit hold_off_req = 1'b0;

	window_gap_planner dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.region_base(region_base), .region_size(region_size), .region_state(region_state),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.gap_base(gap_base), .gap_size(gap_size), .gap_count(gap_count), .last(last)
	);

	gap_plan_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.region_base(region_base), .region_size(region_size), .region_state(region_state),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.gap_base(gap_base), .gap_size(gap_size), .gap_count(gap_count), .last(last),
		.errors(errors), .waiting(waiting)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 17);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_below(input logic [63:0] m);
		return rand64() % m;
	endfunction

	function automatic logic [1:0] pick_state();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return ST_FREE;
		if (r < 85)
			return ST_RESERVED;
		if (r < 93)
			return ST_SPARE;
		return ST_COMMITTED;
	endfunction

	task automatic send(input logic o, input logic [63:0] b, input logic [63:0] s,
			input logic [1:0] st);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		op           <= o;
		region_base  <= b;
		region_size  <= s;
		region_state <= st;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [63:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drain the block, then rewrite the whole window setup.
	task automatic set_window(input logic [63:0] b, input logic [63:0] s, input logic [6:0] lim);
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		apb_write(REG_WIN_BASE, b);
		apb_write(REG_WIN_SIZE, s);
		apb_write(REG_GAP_LIMIT, {57'd0, lim});
	endtask

	initial begin
		logic [63:0] wb;
		logic [63:0] wsz;
		logic [63:0] unit;
		logic [63:0] pos;
		logic [63:0] hole;
		logic [63:0] sz;
		logic [6:0]  lim;
		int          items_sent;
		int          phase;
		int          n;
		int          k;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		op           = OP_REGION;
		region_base  = '0;
		region_size  = '0;
		region_state = ST_FREE;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty window straight after reset
		send(OP_REGION, 64'h0, 64'h10, ST_FREE);
		send(OP_FINISH, 64'h0, 64'h0, ST_FREE);

		// zero gap limit fails even without gaps
		set_window(64'h1000, 64'h100, 7'd0);
		send(OP_REGION, 64'h1000, 64'h100, ST_RESERVED);
		send(OP_FINISH, 64'h0, 64'h0, ST_FREE);

		// window that ends exactly at the top of the address space wraps
		set_window(64'hFFFF_FFFF_FFFF_FFF0, 64'h10, 7'd127);
		send(OP_REGION, 64'hFFFF_FFFF_FFFF_FFF4, 64'h4, ST_FREE);
		send(OP_FINISH, 64'h0, 64'h0, ST_FREE);

		// merging, region before cursor, spare state, three results on finish
		set_window(64'h1000, 64'h100, 7'd127);
		send(OP_REGION, 64'h0800, 64'h100, ST_FREE);
		send(OP_REGION, 64'h0F80, 64'h100, ST_FREE);
		send(OP_REGION, 64'h1080, 64'h20, ST_FREE);
		send(OP_REGION, 64'h10C0, 64'h10, ST_RESERVED);
		send(OP_REGION, 64'h10E0, 64'h10, ST_SPARE);
		send(OP_FINISH, 64'h0, 64'h0, ST_FREE);

		// cursor reaches the window end, later regions are dropped
		send(OP_REGION, 64'h1000, 64'h200, ST_RESERVED);
		send(OP_REGION, 64'h1300, 64'h10, ST_FREE);
		send(OP_FINISH, 64'h0, 64'h0, ST_FREE);

		// committed overlap, then a region after the failure
		send(OP_REGION, 64'h1010, 64'h10, ST_COMMITTED);
		send(OP_REGION, 64'h1040, 64'h10, ST_FREE);
		send(OP_FINISH, 64'h0, 64'h0, ST_FREE);

		// second gap over a limit of one
		set_window(64'h1000, 64'h100, 7'd1);
		send(OP_REGION, 64'h1010, 64'h10, ST_RESERVED);
		send(OP_REGION, 64'h1030, 64'h10, ST_FREE);
		send(OP_FINISH, 64'h0, 64'h0, ST_FREE);

		// top of the address space: wrapping region end, all-ones fields
		set_window(64'hFFFF_FFFF_FFFF_FF00, 64'hFF, 7'd64);
		send(OP_REGION, 64'hFFFF_FFFF_FFFF_FF80, 64'h100, ST_FREE);
		send(OP_REGION, '1, '1, ST_COMMITTED);
		send(OP_REGION, 64'h0, '1, ST_FREE);
		send(OP_FINISH, '1, '1, ST_SPARE);

		// directed items above count toward the total
		items_sent = 25;
		phase      = 0;
		wb         = 64'hFFFF_FFFF_FFFF_FF00;
		wsz        = 64'hFF;
		while (items_sent < 110) begin
			steady = (phase == 2 || phase == 4);
			if (phase == 0 || phase == 4 || $urandom_range(0, 3) != 0) begin
				k   = $urandom_range(0, 15);
				lim = (k == 0) ? 7'd0 : (k == 1) ? 7'($urandom_range(65, 127)) :
					(k < 6) ? 7'($urandom_range(1, 4)) : 7'($urandom_range(5, 64));
				wsz = ($urandom_range(0, 5) == 0) ? rand64() : 64'($urandom_range(1, 4096));
				wb  = rand64();
				if (wb > ~wsz)
					wb = ~wsz;
				k = $urandom_range(0, 9);
				if (k == 0)
					wsz = '0;
				else if (k == 1)
					wb = ~wsz + 64'($urandom_range(1, 64));
				if (phase == 4) begin
					lim = 7'd64;
					wsz = 64'd4096;
					if (wb > ~wsz)
						wb = ~wsz;
				end
				set_window(wb, wsz, lim);
			end
			n    = (phase == 4) ? 24 : $urandom_range(1, 12);
			unit = wsz / (2 * n) + 1;
			pos  = wb - pick_below(unit);
			if (phase == 4)
				hold_off_req = 1'b1;
			for (int i = 0; i < n; i++) begin
				if (phase != 4 && $urandom_range(0, 9) == 0) begin
					send(OP_REGION, rand64(), rand64(), 2'($urandom_range(0, 3)));
					items_sent++;
				end else begin
					hole = (phase == 4 || $urandom_range(0, 2) != 0) ? 1 + pick_below(unit) : 0;
					sz   = ($urandom_range(0, 11) == 0) ? 0 : 1 + pick_below(2 * unit);
					pos  = pos + hole;
					send(OP_REGION, pos, sz, (phase == 4) ? ST_RESERVED : pick_state());
					pos = pos + sz;
					items_sent++;
				end
			end
			if (phase == 4 || $urandom_range(0, 6) != 0) begin
				send(OP_FINISH, rand64(), rand64(), 2'($urandom_range(0, 3)));
				items_sent++;
			end
			phase++;
		end

		steady = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0 && waiting == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
